// File: rtl/pod_pkg.sv
// ============================================================================
// pod_pkg: shared codes of the page ownership directory
// Request function codes and result status codes.
// ============================================================================
package pod_pkg;

  // request function codes
  localparam logic [1:0] FN_READ    = 2'd0;
  localparam logic [1:0] FN_WRITE   = 2'd1;
  localparam logic [1:0] FN_COMMIT  = 2'd2;
  localparam logic [1:0] FN_INVALID = 2'd3;

  // result status codes
  localparam logic [2:0] ST_GRANTED       = 3'd0;
  localparam logic [2:0] ST_LOCAL_HIT     = 3'd1;
  localparam logic [2:0] ST_RETRY         = 3'd2;
  localparam logic [2:0] ST_ALREADY       = 3'd3;
  localparam logic [2:0] ST_BAD           = 3'd4;
  localparam logic [2:0] ST_NOT_PERMITTED = 3'd5;
  localparam logic [2:0] ST_COMMITTED     = 3'd6;

endpackage

// File: rtl/page_ownership_directory.sv
// ============================================================================
// page_ownership_directory: shared page owner directory
// Acquire-read, acquire-write and commit requests against one owner/busy table.
// ============================================================================
// Usage:
//   A request (func, requester, page) transfers in at a rising edge where
//   start is high and busy is low. busy is low except during reset, so one
//   request can be taken every cycle.
//   The owner/busy entry of the page is read from a RAM at acceptance; in the
//   next cycle the decision is made and the entry is written back. A write
//   that hits the page of the request right behind it is forwarded.
//   done and the result are registered from the stage 1 registers and are
//   taken at the edge where done is high; throughput 1 request per cycle.
//   The receiver cannot stall; every result is taken as it appears.
//   Reset (synchronous) clears the pipeline, the counters and one valid bit
//   per page; a page whose valid bit is clear reads as owned by node
//   page modulo NODE_COUNT and not busy, so no clearing pass is needed.
//   grant_total is the grant counter itself and holds between results.
// ============================================================================
module page_ownership_directory #(
  parameter int NODE_COUNT = 4,
  parameter int PAGE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [1:0]  requester,
  input  logic [7:0]  page,
  output logic        done,
  output logic [2:0]  status,
  output logic [1:0]  source_node,
  output logic [1:0]  owner_after,
  output logic [31:0] grant_total,
  output logic [31:0] requester_local_hits
);

  import pod_pkg::*;

  localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int NW    = $clog2(NODE_COUNT);
  localparam int BW    = $clog2(NODE_COUNT + 1);
  localparam int EW    = NW + BW;

  // stage 1 request registers
  logic             s1_valid;
  logic [1:0]       s1_func;
  logic [1:0]       s1_req;
  logic [7:0]       s1_page;

  // table storage
  logic [EW-1:0]    ram_rdata;
  logic [PAGE_COUNT-1:0] valid;
  logic             fwd_hit;
  logic [EW-1:0]    fwd_entry;
  logic [NW-1:0]    reset_owner [PAGE_COUNT];

  // counters
  logic [31:0]      grant_counter;
  logic [31:0]      hit_cnt [NODE_COUNT];

  // decision signals
  logic             accept;
  logic [IDX_W-1:0] idx;
  logic             page_ok;
  logic             req_ok;
  logic [NW-1:0]    req_n;
  logic [BW-1:0]    req_tag;
  logic [NW-1:0]    cur_owner;
  logic [BW-1:0]    cur_busy;
  logic [NW-1:0]    owner_upd;
  logic [BW-1:0]    new_busy;
  logic             tbl_we;
  logic             grant;
  logic             hit_inc;
  logic [2:0]       status_next;
  logic [1:0]       source_next;
  logic [1:0]       owner_after_next;
  logic [31:0]      hit_cur;
  logic [31:0]      hits_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign grant_total = grant_counter;

  // reset owner of each page
  always_comb begin
    for (int i = 0; i < PAGE_COUNT; i++) begin
      reset_owner[i] = NW'(i % NODE_COUNT);
    end
  end

  // owner/busy table
  pod_ram #(
    .WIDTH (EW),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx),
    .wdata ({new_busy, owner_upd}),
    .raddr (page[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_func <= func;
      s1_req  <= requester;
      s1_page <= page;
    end
  end

  // field checks and current entry
  always_comb begin
    idx     = s1_page[IDX_W-1:0];
    page_ok = {1'b0, s1_page} < 9'(PAGE_COUNT);
    req_ok  = {3'b000, s1_req} < 5'(NODE_COUNT);
    req_n   = NW'(s1_req);
    req_tag = BW'(s1_req) + BW'(1);
    if (!page_ok) begin
      cur_owner = '0;
      cur_busy  = '0;
    end else if (fwd_hit) begin
      {cur_busy, cur_owner} = fwd_entry;
    end else if (valid[idx]) begin
      {cur_busy, cur_owner} = ram_rdata;
    end else begin
      cur_owner = reset_owner[idx];
      cur_busy  = '0;
    end
    hit_cur = req_ok ? hit_cnt[req_n] : 32'd0;
  end

  // request decision
  always_comb begin
    status_next = ST_BAD;
    source_next = 2'd0;
    owner_upd   = cur_owner;
    new_busy    = cur_busy;
    tbl_we      = 1'b0;
    grant       = 1'b0;
    hit_inc     = 1'b0;
    if (s1_func != FN_INVALID && page_ok && req_ok) begin
      source_next = 2'(cur_owner);
      case (s1_func)
        FN_COMMIT: begin
          if (cur_owner == req_n && cur_busy == req_tag) begin
            new_busy    = '0;
            tbl_we      = s1_valid;
            status_next = ST_COMMITTED;
          end else begin
            status_next = ST_NOT_PERMITTED;
          end
        end
        FN_READ, FN_WRITE: begin
          if (cur_owner == req_n) begin
            if (s1_func == FN_READ) begin
              hit_inc     = 1'b1;
              status_next = ST_LOCAL_HIT;
            end else begin
              status_next = ST_ALREADY;
            end
          end else if (cur_busy != '0) begin
            status_next = ST_RETRY;
          end else begin
            if (s1_func == FN_WRITE) begin
              owner_upd = req_n;
              new_busy  = req_tag;
              tbl_we    = s1_valid;
            end
            grant       = 1'b1;
            status_next = ST_GRANTED;
          end
        end
        default: begin
          status_next = ST_BAD;
        end
      endcase
    end
    owner_after_next = 2'(owner_upd);
    hits_next        = hit_cur + {31'd0, hit_inc};
  end

  // result and counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      grant_counter <= 32'd0;
      valid         <= '0;
      fwd_hit       <= 1'b0;
      for (int n = 0; n < NODE_COUNT; n++) begin
        hit_cnt[n] <= 32'd0;
      end
    end else begin
      done    <= s1_valid;
      fwd_hit <= tbl_we && accept && (page[IDX_W-1:0] == idx);
      if (s1_valid && grant) begin
        grant_counter <= grant_counter + 32'd1;
      end
      if (s1_valid && hit_inc) begin
        hit_cnt[req_n] <= hits_next;
      end
      if (tbl_we) begin
        valid[idx] <= 1'b1;
      end
    end
  end

  // result payload and forwarded entry
  always_ff @(posedge clk) begin
    fwd_entry <= {new_busy, owner_upd};
    if (s1_valid) begin
      status               <= status_next;
      source_node          <= source_next;
      owner_after          <= owner_after_next;
      requester_local_hits <= hits_next;
    end
  end

  // every result comes from an accepted request
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted request");

  // a grant bumps the counter by one
  a_grant_counts: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_GRANTED && !$past(rst)) |->
      grant_total == $past(grant_total) + 32'd1)
    else $error("grant not counted");

  // no other result moves the grant counter
  a_grant_only: assert property (@(posedge clk) disable iff (rst)
    (!(done && status == ST_GRANTED) && !$past(rst)) |-> $stable(grant_total))
    else $error("grant counter moved without a grant");

  // hit or already-owner leaves ownership where it was
  a_owner_kept: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_LOCAL_HIT || status == ST_ALREADY)) |->
      source_node == owner_after)
    else $error("ownership changed on a local request");

endmodule

// File: rtl/pod_ram.sv
// ============================================================================
// pod_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read-during-write gives old data.
// ============================================================================
module pod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
